@@ src/rmms_pkg.sv @@
package rmms_pkg;

    // Fixed field widths of the channel words
    localparam int unsigned VALUE_W = 24;
    localparam int unsigned MEAN_W  = 32;
    localparam int unsigned STD_W   = 31;
    localparam int unsigned COUNT_W = 16;

    // Input word kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        logic                       kind;
        logic signed [VALUE_W-1:0]  sample_value;
    } sample_word_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  minimum;
        logic signed [VALUE_W-1:0]  maximum;
        logic [VALUE_W-1:0]         spread;
        logic signed [MEAN_W-1:0]   mean_q8;
        logic [STD_W-1:0]           std_dev_q8;
        logic [COUNT_W-1:0]         sample_count;
    } result_word_t;

endpackage

@@ src/rmms_stream_if.sv @@
interface rmms_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/rmms_addsub.sv @@
module rmms_addsub #(
    parameter int unsigned WIDTH = 78
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             carry
);
    // carry on subtract means a >= b
    assign {carry, sum} = {1'b0, a} + {1'b0, (b ^ {WIDTH{sub}})} + (WIDTH+1)'(sub);
endmodule

@@ src/rmms_accum.sv @@
module rmms_accum #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     take,
    input  logic [SAMPLE_BITS-1:0]                   sample_bits,
    input  logic                                     clear,
    output logic signed [SAMPLE_BITS-1:0]            stat_min,
    output logic signed [SAMPLE_BITS-1:0]            stat_max,
    output logic signed [SAMPLE_BITS+COUNT_BITS-1:0] stat_sum,
    output logic [2*SAMPLE_BITS+COUNT_BITS-3:0]      stat_sum_sq,
    output logic [COUNT_BITS-1:0]                    stat_count,
    output logic                                     stat_overflow
);
    localparam int unsigned SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam int unsigned SQ_W  = 2*SAMPLE_BITS + COUNT_BITS - 2;

    logic signed [SAMPLE_BITS-1:0]   pend_reg;
    logic                            pend_valid_reg;
    logic signed [SAMPLE_BITS-1:0]   min_reg;
    logic signed [SAMPLE_BITS-1:0]   max_reg;
    logic signed [SUM_W-1:0]         sum_reg;
    logic [SQ_W-1:0]                 sum_sq_reg;
    logic [COUNT_BITS-1:0]           count_reg;
    logic                            overflow_reg;
    logic signed [2*SAMPLE_BITS-1:0] square;
    logic [SQ_W-1:0]                 square_ext;
    logic                            count_full;

    // one register stage between the sample and its square
    assign square     = pend_reg * pend_reg;
    assign square_ext = SQ_W'(unsigned'(square));
    assign count_full = (count_reg == {COUNT_BITS{1'b1}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            min_reg        <= '0;
            max_reg        <= '0;
            sum_reg        <= '0;
            sum_sq_reg     <= '0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= take;
            if (take)
            begin
                pend_reg <= signed'(sample_bits);
            end
            if (clear)
            begin
                min_reg      <= '0;
                max_reg      <= '0;
                sum_reg      <= '0;
                sum_sq_reg   <= '0;
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else if (pend_valid_reg)
            begin
                if (count_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    if (count_reg == '0 || pend_reg < min_reg)
                    begin
                        min_reg <= pend_reg;
                    end
                    if (count_reg == '0 || pend_reg > max_reg)
                    begin
                        max_reg <= pend_reg;
                    end
                    sum_reg    <= sum_reg + SUM_W'(pend_reg);
                    sum_sq_reg <= sum_sq_reg + square_ext;
                    count_reg  <= count_reg + 1'b1;
                end
            end
        end
    end

    assign stat_min      = min_reg;
    assign stat_max      = max_reg;
    assign stat_sum      = sum_reg;
    assign stat_sum_sq   = sum_sq_reg;
    assign stat_count    = count_reg;
    assign stat_overflow = overflow_reg;

`ifndef SYNTHESIS
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> min_reg <= max_reg)
        else $error("running min above running max");
    a_count_holds_full: assert property (@(posedge clk) disable iff (!rst_n)
        count_full && !clear |=> count_full)
        else $error("saturated count moved");
    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg && !clear |=> overflow_reg)
        else $error("overflow flag dropped without clear");
`endif
endmodule

@@ src/rmms_engine.sv @@
module rmms_engine #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned COUNT_BITS  = 16,
    parameter int unsigned FRAC_BITS   = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     idle,
    output logic                                     clear,
    input  logic signed [SAMPLE_BITS-1:0]            stat_min,
    input  logic signed [SAMPLE_BITS-1:0]            stat_max,
    input  logic signed [SAMPLE_BITS+COUNT_BITS-1:0] stat_sum,
    input  logic [2*SAMPLE_BITS+COUNT_BITS-3:0]      stat_sum_sq,
    input  logic [COUNT_BITS-1:0]                    stat_count,
    input  logic                                     stat_overflow,
    rmms_stream_if.source                            results
);
    import rmms_pkg::*;

    localparam int unsigned SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int unsigned PW     = 2*SAMPLE_BITS + 2*COUNT_BITS - 2;
    localparam int unsigned DW     = PW + 2*FRAC_BITS;
    localparam int unsigned RW     = DW / 2;
    localparam int unsigned QW     = SUM_W + FRAC_BITS;
    localparam int unsigned STEP_W = $clog2(QW);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_MUL1, S_MUL2, S_DIFF, S_SQRT, S_DIV_STD, S_DIV_MEAN, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                out_valid_reg;
    result_word_t        result_reg, result_next;

    logic [PW-1:0]         acc_reg;
    logic [PW-1:0]         p1_reg;
    logic [SUM_W-1:0]      mplr_reg;
    logic [DW-1:0]         rad_reg;
    logic [RW:0]           rem_reg;
    logic [RW-1:0]         root_reg;
    logic [QW-1:0]         divq_reg;
    logic [COUNT_BITS-1:0] drem_reg;
    logic [QW-1:0]         std_reg;
    logic [STEP_W-1:0]     cnt_reg;
    logic                  empty_reg;

    logic [SUM_W-1:0]      mag;
    logic [RW+2:0]         sq_t;
    logic [RW+1:0]         sq_trial;
    logic [COUNT_BITS:0]   div_t;
    logic [RW-1:0]         root_step;
    logic [QW-1:0]         quot_step;
    logic [SAMPLE_BITS:0]  spread_w;
    logic [MEAN_W-1:0]     mean_w;
    logic [PW-1:0]         unit_a, unit_b, unit_sum;
    logic                  unit_sub, unit_carry;
    logic                  last_step;
    logic                  load_result;

    assign mag       = stat_sum[SUM_W-1] ? unsigned'(-stat_sum) : unsigned'(stat_sum);
    assign sq_t      = {rem_reg, rad_reg[DW-1 -: 2]};
    assign sq_trial  = {root_reg, 2'b01};
    assign div_t     = {drem_reg, divq_reg[QW-1]};
    assign root_step = {root_reg[RW-2:0], unit_carry};
    assign quot_step = {divq_reg[QW-2:0], unit_carry};
    assign last_step = (cnt_reg == '0);

    // shared add / subtract-compare unit
    always_comb
    begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b0;
        case (state_reg)
            S_MUL1:
            begin
                unit_a = {acc_reg[PW-2:0], 1'b0};
                unit_b = mplr_reg[SUM_W-1] ? PW'(stat_sum_sq) : '0;
            end
            S_MUL2:
            begin
                unit_a = {acc_reg[PW-2:0], 1'b0};
                unit_b = mplr_reg[SUM_W-1] ? PW'(mag) : '0;
            end
            S_DIFF:
            begin
                unit_a   = p1_reg;
                unit_b   = acc_reg;
                unit_sub = 1'b1;
            end
            S_SQRT:
            begin
                unit_a   = PW'(sq_t);
                unit_b   = PW'(sq_trial);
                unit_sub = 1'b1;
            end
            S_DIV_STD, S_DIV_MEAN:
            begin
                unit_a   = PW'(div_t);
                unit_b   = PW'(stat_count);
                unit_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    rmms_addsub #(.WIDTH(PW)) u_unit (
        .a     (unit_a),
        .b     (unit_b),
        .sub   (unit_sub),
        .sum   (unit_sum),
        .carry (unit_carry)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (start) state_next = S_START;
            S_START:    state_next = (stat_count == '0) ? S_DONE : S_MUL1;
            S_MUL1:     if (last_step) state_next = S_MUL2;
            S_MUL2:     if (last_step) state_next = S_DIFF;
            S_DIFF:     state_next = S_SQRT;
            S_SQRT:     if (last_step) state_next = S_DIV_STD;
            S_DIV_STD:  if (last_step) state_next = S_DIV_MEAN;
            S_DIV_MEAN: if (last_step) state_next = S_DONE;
            S_DONE:     if (load_result) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    assign load_result = (state_reg == S_DONE) && (!out_valid_reg || results.ready);
    assign clear       = load_result;
    assign idle        = (state_reg == S_IDLE);

    assign spread_w = {stat_max[SAMPLE_BITS-1], stat_max} - {stat_min[SAMPLE_BITS-1], stat_min};
    assign mean_w   = MEAN_W'(divq_reg);

    always_comb
    begin
        result_next = '0;
        if (empty_reg)
        begin
            result_next.status = STATUS_EMPTY;
        end
        else
        begin
            result_next.status       = stat_overflow ? STATUS_SATURATED : STATUS_OK;
            result_next.minimum      = VALUE_W'(stat_min);
            result_next.maximum      = VALUE_W'(stat_max);
            result_next.spread       = VALUE_W'(spread_w);
            result_next.mean_q8      = signed'(stat_sum[SUM_W-1] ? -mean_w : mean_w);
            result_next.std_dev_q8   = STD_W'(std_reg);
            result_next.sample_count = COUNT_W'(stat_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
                result_reg    <= result_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_START:
            begin
                empty_reg <= (stat_count == '0);
                acc_reg   <= '0;
                mplr_reg  <= {stat_count, {(SUM_W-COUNT_BITS){1'b0}}};
                cnt_reg   <= STEP_W'(COUNT_BITS - 1);
            end
            S_MUL1:
            begin
                acc_reg  <= unit_sum;
                mplr_reg <= mplr_reg << 1;
                cnt_reg  <= cnt_reg - 1'b1;
                if (last_step)
                begin
                    p1_reg   <= unit_sum;
                    acc_reg  <= '0;
                    mplr_reg <= mag;
                    cnt_reg  <= STEP_W'(SUM_W - 1);
                end
            end
            S_MUL2:
            begin
                acc_reg  <= unit_sum;
                mplr_reg <= mplr_reg << 1;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            S_DIFF:
            begin
                rad_reg  <= unit_carry ? (DW'(unit_sum) << (2*FRAC_BITS)) : '0;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= STEP_W'(RW - 1);
            end
            S_SQRT:
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= unit_carry ? unit_sum[RW:0] : sq_t[RW:0];
                root_reg <= root_step;
                cnt_reg  <= cnt_reg - 1'b1;
                if (last_step)
                begin
                    divq_reg <= QW'(root_step);
                    drem_reg <= '0;
                    cnt_reg  <= STEP_W'(QW - 1);
                end
            end
            S_DIV_STD:
            begin
                divq_reg <= quot_step;
                drem_reg <= unit_carry ? unit_sum[COUNT_BITS-1:0] : div_t[COUNT_BITS-1:0];
                cnt_reg  <= cnt_reg - 1'b1;
                if (last_step)
                begin
                    std_reg  <= quot_step;
                    divq_reg <= QW'(mag) << FRAC_BITS;
                    drem_reg <= '0;
                    cnt_reg  <= STEP_W'(QW - 1);
                end
            end
            S_DIV_MEAN:
            begin
                divq_reg <= quot_step;
                drem_reg <= unit_carry ? unit_sum[COUNT_BITS-1:0] : div_t[COUNT_BITS-1:0];
                cnt_reg  <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign results.valid = out_valid_reg;
    assign results.data  = result_reg;

`ifndef SYNTHESIS
    a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQRT |-> rem_reg <= {root_reg, 1'b0})
        else $error("square root remainder out of range");
    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_STD || state_reg == S_DIV_MEAN) |-> drem_reg < stat_count)
        else $error("divider remainder not below count");
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.status == STATUS_EMPTY
        |-> results.data.sample_count == '0 && results.data.std_dev_q8 == '0)
        else $error("empty result carries statistics");
    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.status != STATUS_EMPTY
        |-> results.data.sample_count != '0 && results.data.minimum <= results.data.maximum)
        else $error("non-empty result is inconsistent");
`endif
endmodule

@@ src/running_min_max_mean_stddev.sv @@
// Running statistics: min, max, spread, mean and population std deviation.
//
// samples (sink): one word per handshake; kind KIND_SAMPLE adds sample_value
//   (low SAMPLE_BITS bits, signed) to the current set, kind KIND_FINISH closes
//   the set and produces one word on results.
// results (source): status, minimum, maximum, spread, mean_q8, std_dev_q8
//   (FRAC_BITS fraction bits) and sample_count; held in an output register.
// Sample words are taken one per cycle while the sequencer is idle; each is
//   squared and accumulated in the cycle after it is taken.
// A finish word runs a sequencer around one shared adder/comparator:
//   shift-add multiplies (COUNT_BITS, then SAMPLE_BITS+COUNT_BITS steps),
//   one subtract, a digit-by-digit square root (SAMPLE_BITS+COUNT_BITS+
//   FRAC_BITS-1 steps) and two restoring divides (SAMPLE_BITS+COUNT_BITS+
//   FRAC_BITS steps each); an empty set goes straight to the result. While
//   the sequencer runs, until the result word is loaded, samples.ready is low.
// If results stalls, the next set still accumulates; a later finish is computed,
//   then waits until the held word is taken. Reset clears the store and the output.
module running_min_max_mean_stddev #(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned COUNT_BITS  = 16,
    parameter int unsigned FRAC_BITS   = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    rmms_stream_if.sink   samples,
    rmms_stream_if.source results
);
    import rmms_pkg::*;

    localparam int unsigned SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam int unsigned SQ_W  = 2*SAMPLE_BITS + COUNT_BITS - 2;

    logic                          idle;
    logic                          take;
    logic                          start;
    logic                          clear;
    logic signed [SAMPLE_BITS-1:0] stat_min;
    logic signed [SAMPLE_BITS-1:0] stat_max;
    logic signed [SUM_W-1:0]       stat_sum;
    logic [SQ_W-1:0]               stat_sum_sq;
    logic [COUNT_BITS-1:0]         stat_count;
    logic                          stat_overflow;

    // input side is open whenever the sequencer is parked
    assign samples.ready = idle;
    assign take  = samples.valid && idle && (samples.data.kind == KIND_SAMPLE);
    assign start = samples.valid && idle && (samples.data.kind == KIND_FINISH);

    // running store: min, max, count, sum, sum of squares
    rmms_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .sample_bits   (samples.data.sample_value[SAMPLE_BITS-1:0]),
        .clear         (clear),
        .stat_min      (stat_min),
        .stat_max      (stat_max),
        .stat_sum      (stat_sum),
        .stat_sum_sq   (stat_sum_sq),
        .stat_count    (stat_count),
        .stat_overflow (stat_overflow)
    );

    // finish sequencer; clears the store when its word is loaded
    rmms_engine #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .idle          (idle),
        .clear         (clear),
        .stat_min      (stat_min),
        .stat_max      (stat_max),
        .stat_sum      (stat_sum),
        .stat_sum_sq   (stat_sum_sq),
        .stat_count    (stat_count),
        .stat_overflow (stat_overflow),
        .results       (results)
    );
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import rmms_pkg::*;

    // Block defaults: 8 fraction bits, count saturates at 2^16 - 1.
    localparam int          FRAC_BITS   = 8;
    localparam int unsigned COUNT_LIMIT = (1 << COUNT_W) - 1;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // Slowest legal gap between handshakes is a finish behind the long result
    // hold-off plus a receiver stall; keep a wide margin.
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 700;
    localparam int DRAIN_CYCLES = 300;
    localparam int MAX_GAP = 18;

    logic clk;
    logic rst_n;

    rmms_stream_if #(.word_t(sample_word_t)) sample_ch ();
    rmms_stream_if #(.word_t(result_word_t)) stats_ch ();

    running_min_max_mean_stddev uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (stats_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Idle knobs, changed per test; 0 means no idling on that side.
    int send_gap_max = 0;
    int recv_gap_max = 0;
    int holdoff_len = 0;
    logic holdoff_active = 1'b0;

    // Predicted store of the current data set.
    logic signed [VALUE_W-1:0] set_min;
    logic signed [VALUE_W-1:0] set_max;
    longint                    set_sum;
    logic [63:0]               set_sum_sq;
    int unsigned               set_count;
    logic                      set_saturated;

    // Statistics words predicted but not yet seen on the results channel.
    result_word_t pending_stats[$];

    int sample_words = 0;
    int finish_words = 0;
    int stats_checked = 0;
    int empty_sets = 0;
    int saturated_sets = 0;
    int mismatch_count = 0;
    int longest_input_stall = 0;

    function automatic int draw_gap(input int max_gap);
        return (max_gap == 0) ? 0 : int'($urandom_range(0, max_gap));
    endfunction

    function automatic void clear_set();
        set_min = '0;
        set_max = '0;
        set_sum = 0;
        set_sum_sq = '0;
        set_count = 0;
        set_saturated = 1'b0;
    endfunction

    // Sample word: fold into the running set, or drop it once count is full.
    function automatic void fold_sample(input logic signed [VALUE_W-1:0] value);
        longint wide;
        wide = value;
        if (set_count >= COUNT_LIMIT) begin
            set_saturated = 1'b1;
            return;
        end
        if (set_count == 0) begin
            set_min = value;
            set_max = value;
        end else begin
            if (value < set_min)
                set_min = value;
            if (value > set_max)
                set_max = value;
        end
        set_sum += wide;
        set_sum_sq += wide * wide;
        set_count++;
    endfunction

    // Finish word: build the statistics word, then clear the set.
    // std = floor(isqrt((n*sum_sq - sum^2) * 4^FRAC) / n), all exact.
    function automatic result_word_t close_data_set();
        result_word_t w;
        longint       mean;
        longint       span;
        logic [63:0]  mag;
        logic [127:0] num;
        logic [127:0] sq_sum;
        logic [127:0] root;
        logic [127:0] trial;
        logic [127:0] quot;
        int           b;
        w = '0;
        if (set_count == 0) begin
            w.status = STATUS_EMPTY;
            empty_sets++;
        end else begin
            mean = (set_sum * (longint'(1) << FRAC_BITS)) / longint'(set_count);
            span = longint'(set_max) - longint'(set_min);
            mag = (set_sum < 0) ? -set_sum : set_sum;
            num = 128'(set_count) * 128'(set_sum_sq);
            sq_sum = 128'(mag) * 128'(mag);
            num = (sq_sum <= num) ? num - sq_sum : '0;
            num = num << (2 * FRAC_BITS);
            root = '0;
            for (b = 47; b >= 0; b--) begin
                trial = root | (128'(1) << b);
                if (trial * trial <= num)
                    root = trial;
            end
            quot = root / 128'(set_count);
            w.status = set_saturated ? STATUS_SATURATED : STATUS_OK;
            w.minimum = set_min;
            w.maximum = set_max;
            w.spread = span[VALUE_W-1:0];
            w.mean_q8 = mean[MEAN_W-1:0];
            w.std_dev_q8 = quot[STD_W-1:0];
            w.sample_count = set_count[COUNT_W-1:0];
            if (set_saturated)
                saturated_sets++;
        end
        clear_set();
        return w;
    endfunction

    function automatic string fmt_stats(input result_word_t w);
        return $sformatf("status=%0d min=%0d max=%0d spread=%0d mean_q8=%0d std_q8=%0d n=%0d",
                         w.status, w.minimum, w.maximum, w.spread, w.mean_q8,
                         w.std_dev_q8, w.sample_count);
    endfunction

    task automatic check_stats(input result_word_t got);
        result_word_t want;
        string        bad;
        if (pending_stats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] unexpected stats word: %s", $realtime, fmt_stats(got));
            return;
        end
        want = pending_stats.pop_front();
        stats_checked++;
        bad = "";
        if (got.status !== want.status)             bad = {bad, " status"};
        if (got.minimum !== want.minimum)           bad = {bad, " minimum"};
        if (got.maximum !== want.maximum)           bad = {bad, " maximum"};
        if (got.spread !== want.spread)             bad = {bad, " spread"};
        if (got.mean_q8 !== want.mean_q8)           bad = {bad, " mean_q8"};
        if (got.std_dev_q8 !== want.std_dev_q8)     bad = {bad, " std_dev_q8"};
        if (got.sample_count !== want.sample_count) bad = {bad, " sample_count"};
        if (bad != "") begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] stats word %0d wrong:%s\n  expected %s\n  actual   %s",
                         $realtime, stats_checked, bad, fmt_stats(want), fmt_stats(got));
        end
    endtask

    // Offer one word; valid stays high across back-to-back words so it gets
    // only one NBA per time step. Prediction runs at the accepting edge.
    task automatic send_word(input logic kind, input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = draw_gap(send_gap_max);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data <= {kind, value};
        do
            @(posedge clk);
        while (!sample_ch.ready);
        if (kind == KIND_SAMPLE) begin
            sample_words++;
            fold_sample(value);
        end else begin
            finish_words++;
            pending_stats.push_back(close_data_set());
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(input int mode,
                                                           input logic [VALUE_W-1:0] base);
        case (mode)
            0: return VALUE_W'($urandom);
            1: return base + VALUE_W'($urandom_range(0, 31)) - VALUE_W'(16);
            2: case ($urandom_range(0, 3))
                   0: return VALUE_MIN;
                   1: return VALUE_MAX;
                   2: return '0;
                   default: return '1;
               endcase
            default: return base;
        endcase
    endfunction

    // Short sets aimed at the corners: empty set, lone extremes, full-range
    // spread, mean truncating toward zero, zero deviation, back-to-back finish.
    task automatic test_directed_sets();
        send_gap_max = 0;
        recv_gap_max = 0;
        send_word(KIND_FINISH, '0);
        send_word(KIND_SAMPLE, VALUE_MIN);
        send_word(KIND_FINISH, '0);
        send_word(KIND_SAMPLE, VALUE_MAX);
        send_word(KIND_FINISH, VALUE_MIN);
        send_word(KIND_SAMPLE, VALUE_MAX);
        send_word(KIND_SAMPLE, VALUE_MIN);
        send_word(KIND_FINISH, VALUE_MAX);
        send_word(KIND_SAMPLE, -24'sd1);
        send_word(KIND_SAMPLE, -24'sd1);
        send_word(KIND_SAMPLE, 24'sd0);
        send_word(KIND_FINISH, '1);
        send_word(KIND_SAMPLE, -24'sd1);
        send_word(KIND_SAMPLE, -24'sd1);
        send_word(KIND_SAMPLE, -24'sd1);
        send_word(KIND_FINISH, '0);
        send_word(KIND_FINISH, '0);
        send_word(KIND_FINISH, '0);
    endtask

    // Longer sets at the value extremes: a run of most-negative samples
    // (largest sum and square magnitudes), then alternating extremes for the
    // widest deviation. A short set after must read back clean.
    task automatic test_extreme_sets();
        int n;
        send_gap_max = 0;
        recv_gap_max = MAX_GAP;
        for (n = 0; n < 200; n++)
            send_word(KIND_SAMPLE, VALUE_MIN);
        send_word(KIND_FINISH, '0);
        for (n = 0; n < 150; n++)
            send_word(KIND_SAMPLE, (n % 2 == 0) ? VALUE_MAX : VALUE_MIN);
        send_word(KIND_FINISH, '0);
        send_word(KIND_SAMPLE, 24'sd77);
        send_word(KIND_FINISH, '0);
    endtask

    // Hold results off for a long stretch while sets keep coming, so a held
    // stats word blocks the next finish and the input stalls behind it.
    task automatic test_stall_under_backpressure();
        int i;
        send_gap_max = 0;
        recv_gap_max = 0;
        holdoff_len = HOLDOFF_CYCLES;
        for (i = 0; i < 8; i++)
            send_word(KIND_SAMPLE, pick_value(0, '0));
        send_word(KIND_FINISH, '0);
        for (i = 0; i < 40; i++)
            send_word(KIND_SAMPLE, pick_value(1, 24'h00_1000));
        send_word(KIND_FINISH, '0);
        for (i = 0; i < 5; i++)
            send_word(KIND_SAMPLE, pick_value(0, '0));
        send_word(KIND_FINISH, '0);
    endtask

    // Random sets: mostly short, a few long, some empty; value style and
    // idle profile drawn per set.
    task automatic test_random_sets(input int word_budget);
        int                 sent;
        int                 set_len;
        int                 mode;
        int                 i;
        logic [VALUE_W-1:0] base;
        sent = 0;
        while (sent < word_budget) begin
            case ($urandom_range(0, 3))
                0: begin send_gap_max = 0;       recv_gap_max = 0;       end
                1: begin send_gap_max = MAX_GAP; recv_gap_max = MAX_GAP; end
                2: begin send_gap_max = MAX_GAP; recv_gap_max = 0;       end
                default: begin send_gap_max = 0; recv_gap_max = MAX_GAP; end
            endcase
            i = $urandom_range(0, 99);
            if (i < 5)
                set_len = 0;
            else if (i < 85)
                set_len = $urandom_range(1, 16);
            else if (i < 97)
                set_len = $urandom_range(17, 60);
            else
                set_len = $urandom_range(61, 300);
            mode = $urandom_range(0, 3);
            base = VALUE_W'($urandom);
            for (i = 0; i < set_len; i++)
                send_word(KIND_SAMPLE, pick_value(mode, base));
            send_word(KIND_FINISH, VALUE_W'($urandom));
            sent += set_len + 1;
        end
    endtask

    // Receiver: check each accepted word, then draw a stall before the next.
    initial
    begin : stats_receiver
        int hold_left;
        hold_left = 0;
        stats_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && stats_ch.valid && stats_ch.ready) begin
                check_stats(stats_ch.data);
                hold_left = draw_gap(recv_gap_max);
            end
            if (holdoff_active || hold_left > 0) begin
                stats_ch.ready <= 1'b0;
                if (hold_left > 0)
                    hold_left--;
            end else begin
                stats_ch.ready <= 1'b1;
            end
        end
    end

    // Long result hold-off, counted here so the sender keeps running.
    initial
    begin : holdoff_timer
        forever begin
            wait (holdoff_len > 0);
            @(posedge clk);
            holdoff_active <= 1'b1;
            repeat (holdoff_len) @(posedge clk);
            holdoff_active <= 1'b0;
            holdoff_len = 0;
        end
    end

    // Watchdog: cycles with no handshake on either channel; also tracks the
    // longest run of the input being held off.
    initial
    begin : watchdog
        int quiet_cycles;
        int stall_run;
        quiet_cycles = 0;
        stall_run = 0;
        forever begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (stats_ch.valid && stats_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (sample_ch.valid === 1'b1 && sample_ch.ready !== 1'b1) begin
                stall_run++;
                if (stall_run > longest_input_stall)
                    longest_input_stall = stall_run;
            end else begin
                stall_run = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] no handshake for %0d cycles, %0d stats words outstanding",
                         $realtime, quiet_cycles, pending_stats.size());
                $display("FAIL running_min_max_mean_stddev");
                $finish;
            end
        end
    end

    initial
    begin : main_sequence
        rst_n <= 1'b0;
        sample_ch.valid <= 1'b0;
        sample_ch.data <= '0;
        clear_set();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_sets();
        test_extreme_sets();
        test_stall_under_backpressure();
        test_random_sets(1200);

        // last word already accepted; release the input and drain
        sample_ch.valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d sample words, %0d finish words, %0d stats words checked",
                 sample_words, finish_words, stats_checked);
        $display("  %0d empty sets, %0d saturated sets, longest input stall %0d cycles",
                 empty_sets, saturated_sets, longest_input_stall);
        if (mismatch_count == 0 && pending_stats.size() == 0) begin
            $display("PASS running_min_max_mean_stddev");
        end else begin
            $display("%0d mismatches, %0d stats words never seen",
                     mismatch_count, pending_stats.size());
            $display("FAIL running_min_max_mean_stddev");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/rmms_pkg.sv
src/rmms_stream_if.sv
src/rmms_addsub.sv
src/rmms_accum.sv
src/rmms_engine.sv
src/running_min_max_mean_stddev.sv
sim/testbench.sv
